### rtl/ocwm_pkg.sv
// Shared types, codes and helpers of the omni chassis wheel mixer.
`timescale 1ns / 1ps
package ocwm_pkg;

  localparam int WHEEL_COUNT = 4;
  localparam int MUL_A_W     = 42;
  localparam int MUL_B_W     = 24;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W   = $clog2(MUL_B_W);

  localparam logic [2:0] MODE_RELAX  = 3'd0;
  localparam logic [2:0] MODE_FOLLOW = 3'd1;
  localparam logic [2:0] MODE_SPIN   = 3'd2;
  localparam logic [2:0] MODE_OPEN   = 3'd3;
  localparam logic [2:0] MODE_STOP   = 3'd4;
  localparam logic [2:0] MODE_FLY    = 3'd5;
  localparam logic [2:0] MODE_AUTO   = 3'd6;
  localparam logic [2:0] MODE_OTHER  = 3'd7;

  localparam logic [2:0] REG_MAX_X    = 3'd0;
  localparam logic [2:0] REG_MAX_Y    = 3'd1;
  localparam logic [2:0] REG_MAX_TURN = 3'd2;
  localparam logic [2:0] REG_TURN_ARM = 3'd3;
  localparam logic [2:0] REG_RPM      = 3'd4;

  // bit i set: wheel i takes the negated term
  localparam logic [WHEEL_COUNT-1:0] MIX_X_NEG = 4'b1100;
  localparam logic [WHEEL_COUNT-1:0] MIX_Y_NEG = 4'b0110;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic signed [15:0] clamp_sym(input logic signed [17:0] v,
                                                   input logic [14:0] lim);
    logic signed [17:0] l;
    l = signed'({3'b000, lim});
    if (v > l) return 16'(l);
    if (v < -l) return 16'(-l);
    return 16'(v);
  endfunction

endpackage

### rtl/ocwm_if.sv
// Valid/ready channels for command items and wheel result items.
`timescale 1ns / 1ps
interface ocwm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         mode;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_turn;
  logic [15:0]        rel_angle;
  modport source(output valid, mode, vel_x, vel_y, vel_turn, rel_angle, input ready);
  modport sink(input valid, mode, vel_x, vel_y, vel_turn, rel_angle, output ready);
endinterface

interface ocwm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel_0;
  logic signed [15:0] wheel_1;
  logic signed [15:0] wheel_2;
  logic signed [15:0] wheel_3;
  logic               relax_motors;
  logic               saturated;
  modport source(output valid, wheel_0, wheel_1, wheel_2, wheel_3, relax_motors, saturated,
                 input ready);
  modport sink(input valid, wheel_0, wheel_1, wheel_2, wheel_3, relax_motors, saturated,
               output ready);
endinterface

### rtl/ocwm_ser_mul.sv
// Bit-serial shift-add unsigned multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module ocwm_ser_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  ocwm_pkg::mul_req_t req,
  output ocwm_pkg::mul_rsp_t rsp
);
  import ocwm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MUL_A_W-1:0]   a_r;
  logic [MUL_B_W-1:0]   b_r;
  logic [MUL_P_W-1:0]   acc_r;
  logic [MUL_A_W:0]     hi;

  assign hi = {1'b0, acc_r[MUL_P_W-1:MUL_B_W]} + (b_r[0] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= MUL_CNT_W'(MUL_B_W - 1);
        a_r    <= req.a;
        b_r    <= req.b;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r <= {hi, acc_r[MUL_B_W-1:1]};
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

### rtl/ocwm_sine_rom.sv
// Q1.15 sine ROM built at elaboration, registered read.
`timescale 1ns / 1ps
module ocwm_sine_rom #(
  parameter int ENTRIES = 1024,
  parameter int ADDR_W  = $clog2(ENTRIES)
) (
  input  logic                     clk,
  input  logic [ADDR_W-1:0]        addr,
  output logic signed [15:0]       data_r
);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [15:0] rom_t [ENTRIES];

  function automatic rom_t build_rom();
    rom_t               rom;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    int                 q;
    int                 rem;
    int                 rr;
    int                 v;
    for (int k = 0; k < ENTRIES; k++) begin
      q    = (4 * k) / ENTRIES;
      rem  = (4 * k) % ENTRIES;
      rr   = (q % 2 == 1) ? ENTRIES - rem : rem;
      x    = HALF_PI_Q30 * 64'(rr) / 64'(ENTRIES);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      if (sum < 0) begin
        v = 0;
      end else begin
        r = (sum + 64'sd16384) >>> 15;
        v = (r > 64'sd32767) ? 32767 : int'(r);
      end
      rom[k] = 16'((q >= 2) ? -v : v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    data_r <= SINE_ROM[addr];
  end

endmodule

### rtl/omni_chassis_wheel_mixer.sv
// Omni chassis wheel mixer top level: sequencer, config registers, output stage.
// Stop, fly, auto, relax and other modes go from accept straight to the result stage (S_DONE).
// Open loop clamps and then runs 5 multiplies; follow and spin first add the table reads (S_SIN,
// S_COS, S_CWAIT), 4 rotation multiplies and a rounding state (S_ROT).
// One item in flight; the next item is accepted once the result sits in the output register.
// Reset: wheel targets clear to zero, limits load their defaults; no clearing pass.
`timescale 1ns / 1ps
module omni_chassis_wheel_mixer #(
  parameter int SINE_TABLE_ENTRIES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  ocwm_in_if.sink     in_if,
  ocwm_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);
  import ocwm_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE, S_SIN, S_COS, S_CWAIT, S_MSTART, S_MUL, S_ROT, S_CLAMP, S_DONE
  } state_t;

  state_t              state_r;
  logic [3:0]          op_r;
  logic [2:0]          mode_r;
  logic signed [15:0]  vx_r, vy_r, vw_r;
  logic [15:0]         ang_r;
  logic signed [15:0]  sin_r, cos_r;
  logic signed [32:0]  p0_r, p1_r, p2_r;
  logic signed [17:0]  wx_r, wy_r;
  logic signed [15:0]  cx_r, cy_r, cw_r;
  logic signed [40:0]  tw_r;
  logic                neg_r;
  logic signed [15:0]  tgt_r [WHEEL_COUNT];
  logic                sat_r, relax_r;
  logic [14:0]         max_x_r, max_y_r, max_turn_r;
  logic [23:0]         turn_arm_r, rpm_r;
  logic                out_valid_r;
  logic signed [15:0]  out_w_r [WHEEL_COUNT];
  logic                out_relax_r, out_sat_r;

  mul_req_t            mul_req;
  mul_rsp_t            mul_rsp;
  logic [IDX_W-1:0]    rom_addr;
  logic signed [15:0]  rom_data;

  logic [1:0]          wi;
  logic signed [17:0]  lin;
  logic signed [41:0]  wsum;
  logic                op_neg;
  logic [MUL_P_W-1:0]  p_signed;
  logic [MUL_P_W:0]    p_rnd;
  logic [34:0]         rmag;
  logic signed [33:0]  rot_x, rot_y;

  function automatic logic [IDX_W-1:0] sin_index(input logic [15:0] a);
    logic [31:0] t;
    t = 32'(a) * 32'(SINE_TABLE_ENTRIES);
    return t[16 +: IDX_W];
  endfunction

  assign rom_addr = (state_r == S_SIN) ? sin_index(ang_r) : sin_index(ang_r + 16'd16384);

  ocwm_sine_rom #(.ENTRIES(SINE_TABLE_ENTRIES)) u_rom (
    .clk(clk), .addr(rom_addr), .data_r(rom_data)
  );

  ocwm_ser_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));

  assign wi   = 2'(op_r - 4'd5);
  assign lin  = (MIX_X_NEG[wi] ? -18'(cx_r) : 18'(cx_r))
              + (MIX_Y_NEG[wi] ? -18'(cy_r) : 18'(cy_r));
  assign wsum = (42'(lin) <<< 16) + 42'(tw_r);

  always_comb begin
    mul_req.start = (state_r == S_MSTART);
    mul_req.a     = '0;
    mul_req.b     = '0;
    op_neg        = 1'b0;
    unique case (op_r)
      4'd0: begin
        mul_req.a = MUL_A_W'(abs16(vx_r));
        mul_req.b = MUL_B_W'(abs16(cos_r));
        op_neg    = vx_r[15] ^ cos_r[15];
      end
      4'd1: begin
        mul_req.a = MUL_A_W'(abs16(vy_r));
        mul_req.b = MUL_B_W'(abs16(sin_r));
        op_neg    = vy_r[15] ^ sin_r[15];
      end
      4'd2: begin
        mul_req.a = MUL_A_W'(abs16(vx_r));
        mul_req.b = MUL_B_W'(abs16(sin_r));
        op_neg    = vx_r[15] ^ sin_r[15];
      end
      4'd3: begin
        mul_req.a = MUL_A_W'(abs16(vy_r));
        mul_req.b = MUL_B_W'(abs16(cos_r));
        op_neg    = vy_r[15] ^ cos_r[15];
      end
      4'd4: begin
        mul_req.a = MUL_A_W'(abs16(cw_r));
        mul_req.b = turn_arm_r;
        op_neg    = cw_r[15];
      end
      4'd5, 4'd6, 4'd7, 4'd8: begin
        mul_req.a = wsum[41] ? 42'(-wsum) : 42'(wsum);
        mul_req.b = rpm_r;
        op_neg    = wsum[41];
      end
      default: begin
        mul_req.a = '0;
      end
    endcase
  end

  assign p_signed = neg_r ? -mul_rsp.prod : mul_rsp.prod;
  assign p_rnd    = {1'b0, mul_rsp.prod} + (MUL_P_W + 1)'(64'h8000_0000);
  assign rmag     = p_rnd[MUL_P_W:32];
  assign rot_x    = (34'(p0_r) - 34'(p1_r) + 34'sd16384) >>> 15;
  assign rot_y    = (34'(p2_r) + 34'(p_signed[32:0]) + 34'sd16384) >>> 15;

  assign in_if.ready          = (state_r == S_IDLE);
  assign out_if.valid         = out_valid_r;
  assign out_if.wheel_0       = out_w_r[0];
  assign out_if.wheel_1       = out_w_r[1];
  assign out_if.wheel_2       = out_w_r[2];
  assign out_if.wheel_3       = out_w_r[3];
  assign out_if.relax_motors  = out_relax_r;
  assign out_if.saturated     = out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_x_r    <= 15'd3000;
      max_y_r    <= 15'd3000;
      max_turn_r <= 15'd300;
      turn_arm_r <= 24'd65536;
      rpm_r      <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MAX_X:    max_x_r    <= cfg_wdata[14:0];
        REG_MAX_Y:    max_y_r    <= cfg_wdata[14:0];
        REG_MAX_TURN: max_turn_r <= cfg_wdata[14:0];
        REG_TURN_ARM: turn_arm_r <= cfg_wdata;
        REG_RPM:      rpm_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= '0;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      relax_r     <= 1'b0;
      for (int i = 0; i < WHEEL_COUNT; i++) tgt_r[i] <= '0;
    end else begin
      if (out_valid_r && out_if.ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            mode_r  <= in_if.mode;
            vx_r    <= in_if.vel_x;
            vy_r    <= in_if.vel_y;
            vw_r    <= in_if.vel_turn;
            ang_r   <= in_if.rel_angle;
            wx_r    <= 18'(in_if.vel_x);
            wy_r    <= 18'(in_if.vel_y);
            sat_r   <= 1'b0;
            relax_r <= (in_if.mode == MODE_RELAX) || (in_if.mode == MODE_OTHER);
            priority if (in_if.mode == MODE_FOLLOW || in_if.mode == MODE_SPIN) begin
              state_r <= S_SIN;
            end else if (in_if.mode == MODE_OPEN) begin
              state_r <= S_CLAMP;
            end else if (in_if.mode == MODE_STOP) begin
              for (int i = 0; i < WHEEL_COUNT; i++) tgt_r[i] <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_SIN: state_r <= S_COS;
        S_COS: begin
          sin_r   <= rom_data;
          state_r <= S_CWAIT;
        end
        S_CWAIT: begin
          cos_r   <= rom_data;
          op_r    <= 4'd0;
          state_r <= S_MSTART;
        end
        S_MSTART: begin
          neg_r   <= op_neg;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (mul_rsp.done) begin
            op_r <= op_r + 4'd1;
            unique case (op_r)
              4'd0: begin p0_r <= p_signed[32:0]; state_r <= S_MSTART; end
              4'd1: begin p1_r <= p_signed[32:0]; state_r <= S_MSTART; end
              4'd2: begin p2_r <= p_signed[32:0]; state_r <= S_MSTART; end
              4'd3: state_r <= S_ROT;
              4'd4: begin tw_r <= p_signed[40:0]; state_r <= S_MSTART; end
              4'd5, 4'd6, 4'd7, 4'd8: begin
                if (neg_r) begin
                  if (rmag > 35'd32768) begin
                    tgt_r[wi] <= -16'sd32768;
                    sat_r     <= 1'b1;
                  end else begin
                    tgt_r[wi] <= 16'(-rmag);
                  end
                end else begin
                  if (rmag > 35'd32767) begin
                    tgt_r[wi] <= 16'sd32767;
                    sat_r     <= 1'b1;
                  end else begin
                    tgt_r[wi] <= 16'(rmag);
                  end
                end
                state_r <= (op_r == 4'd8) ? S_DONE : S_MSTART;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_ROT: begin
          wx_r    <= 18'(rot_x);
          wy_r    <= 18'(rot_y);
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          cx_r    <= clamp_sym(wx_r, max_x_r);
          cy_r    <= clamp_sym(wy_r, max_y_r);
          cw_r    <= clamp_sym(18'(vw_r), max_turn_r);
          op_r    <= 4'd4;
          state_r <= S_MSTART;
        end
        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            for (int i = 0; i < WHEEL_COUNT; i++) out_w_r[i] <= tgt_r[i];
            out_relax_r <= relax_r;
            out_sat_r   <= sat_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> state_r == S_MUL)
    else $error("multiplier finished outside its wait state");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && mode_r == MODE_STOP) |->
      (tgt_r[0] == 0 && tgt_r[1] == 0 && tgt_r[2] == 0 && tgt_r[3] == 0))
    else $error("stop left nonzero wheel targets");

  a_sat_calc_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && sat_r) |->
      (mode_r == MODE_FOLLOW || mode_r == MODE_SPIN || mode_r == MODE_OPEN))
    else $error("saturation flagged in a mode without mixing");
`endif

endmodule

### verif/omni_chassis_wheel_mixer_tb.sv
// Self-checking testbench of the omni chassis wheel mixer: directed table, random commands.
`timescale 1ns / 1ps
module omni_chassis_wheel_mixer_tb;
  import ocwm_pkg::*;

  localparam int TAB_N      = 1024;
  localparam int CYCLE_MAX  = 1000000;
  localparam int RAND_ITEMS = 450;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vw;
    logic [15:0]        ang;
  } cmd_t;

  typedef struct packed {
    logic [3:0][15:0] w;
    logic             relax;
    logic             sat;
  } wheels_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    typed;
    wheels_t want;
  } row_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  ocwm_in_if  in_ch();
  ocwm_out_if out_ch();

  omni_chassis_wheel_mixer dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  int          sin_q15[TAB_N];
  logic [15:0] held_w[4];
  logic [14:0] lim_x, lim_y, lim_turn;
  logic [23:0] arm_q16, rpm_q16;
  wheels_t     wheels_due[$];
  int          send_idle_pct, recv_stall_pct;
  int          mismatches, results_seen, sat_seen, relax_seen, cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int taylor_q15(longint unsigned x);
    longint unsigned x2, term;
    longint sum, r;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) return 0;
    r = (sum + 16384) >>> 15;
    return (r > 32767) ? 32767 : int'(r);
  endfunction

  function automatic longint sine_at(logic [15:0] ang);
    return longint'(sin_q15[(int'(ang) * TAB_N) >> 16]);
  endfunction

  function automatic longint round_half_up_q15(longint n);
    longint m;
    m = n + 16384;
    if (m >= 0) return m >>> 15;
    return -(((-m) + 32767) >>> 15);
  endfunction

  function automatic longint limit_to(longint v, logic [14:0] lim);
    if (v > longint'(lim)) return longint'(lim);
    if (v < -longint'(lim)) return -longint'(lim);
    return v;
  endfunction

  function automatic logic [15:0] rpm_saturate(longint s, ref logic sat);
    longint unsigned m, a, b, r;
    m = (s < 0) ? longint'(-s) : longint'(s);
    a = (m >> 16) * rpm_q16;
    b = (m & 64'hFFFF) * rpm_q16 + 64'h8000_0000;
    r = (a + (b >> 16)) >> 16;
    if (s < 0) begin
      if (r > 32768) begin
        sat = 1'b1;
        return 16'h8000;
      end
      return 16'(-longint'(r));
    end
    if (r > 32767) begin
      sat = 1'b1;
      return 16'h7FFF;
    end
    return 16'(r);
  endfunction

  function automatic wheels_t mix_command(cmd_t c);
    wheels_t res;
    longint vx, vy, vw, s, co, nx, lin;
    logic sat;
    vx = c.vx;
    vy = c.vy;
    vw = c.vw;
    sat = 1'b0;
    res.relax = (c.mode == MODE_RELAX) || (c.mode == MODE_OTHER);
    if (c.mode == MODE_FOLLOW || c.mode == MODE_SPIN || c.mode == MODE_OPEN) begin
      if (c.mode != MODE_OPEN) begin
        s  = sine_at(c.ang);
        co = sine_at(c.ang + 16'd16384);
        nx = round_half_up_q15(vx * co - vy * s);
        vy = round_half_up_q15(vx * s + vy * co);
        vx = nx;
      end
      vx = limit_to(vx, lim_x);
      vy = limit_to(vy, lim_y);
      vw = limit_to(vw, lim_turn);
      for (int i = 0; i < 4; i++) begin
        lin = (MIX_X_NEG[i] ? -vx : vx) + (MIX_Y_NEG[i] ? -vy : vy);
        held_w[i] = rpm_saturate(lin * 65536 + vw * longint'(arm_q16), sat);
      end
    end else if (c.mode == MODE_STOP) begin
      for (int i = 0; i < 4; i++) held_w[i] = '0;
    end
    for (int i = 0; i < 4; i++) res.w[i] = held_w[i];
    res.sat = sat;
    return res;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_MAX_X:    lim_x = val[14:0];
      REG_MAX_Y:    lim_y = val[14:0];
      REG_MAX_TURN: lim_turn = val[14:0];
      REG_TURN_ARM: arm_q16 = val;
      REG_RPM:      rpm_q16 = val;
      default: ;
    endcase
  endtask

  task automatic load_limits(logic [23:0] mx, logic [23:0] my, logic [23:0] mt,
                             logic [23:0] arm, logic [23:0] rpm);
    while (wheels_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    write_reg(REG_MAX_X, mx);
    write_reg(REG_MAX_Y, my);
    write_reg(REG_MAX_TURN, mt);
    write_reg(REG_TURN_ARM, arm);
    write_reg(REG_RPM, rpm);
  endtask

  task automatic send_cmd(cmd_t c, logic typed, wheels_t want);
    wheels_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.mode = c.mode;
    in_ch.vel_x = c.vx;
    in_ch.vel_y = c.vy;
    in_ch.vel_turn = c.vw;
    in_ch.rel_angle = c.ang;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = mix_command(c);
    wheels_due.push_back(typed ? want : pred);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.mode = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) c.mode = MODE_FOLLOW;
    if ($urandom_range(0, 2) == 0) begin
      c.vx = 16'($urandom);
      c.vy = 16'($urandom);
      c.vw = 16'($urandom);
    end else begin
      c.vx = 16'(int'($urandom_range(0, 8000)) - 4000);
      c.vy = 16'(int'($urandom_range(0, 8000)) - 4000);
      c.vw = 16'(int'($urandom_range(0, 800)) - 400);
    end
    c.ang = 16'($urandom);
    return c;
  endfunction

  function automatic wheels_t flat(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2,
                                   logic [15:0] v3, logic rl);
    wheels_t r;
    r.w[0] = v0;
    r.w[1] = v1;
    r.w[2] = v2;
    r.w[3] = v3;
    r.relax = rl;
    r.sat = 1'b0;
    return r;
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycles);
      $display("omni_chassis_wheel_mixer_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    wheels_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.w[0] = out_ch.wheel_0;
      got.w[1] = out_ch.wheel_1;
      got.w[2] = out_ch.wheel_2;
      got.w[3] = out_ch.wheel_3;
      got.relax = out_ch.relax_motors;
      got.sat = out_ch.saturated;
      results_seen++;
      sat_seen += got.sat;
      relax_seen += got.relax;
      if (wheels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = wheels_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected w=%p relax=%b sat=%b, got w=%p relax=%b sat=%b",
                     want.w, want.relax, want.sat, got.w, got.relax, got.sat);
        end
      end
    end
  end

  initial begin
    row_t    rows[$];
    row_t    r;
    wheels_t none;
    for (int k = 0; k < TAB_N; k++) begin
      int unsigned t, q, rem, rr;
      int v;
      t = 4 * k;
      q = t / TAB_N;
      rem = t % TAB_N;
      rr = (q % 2 == 1) ? TAB_N - rem : rem;
      v = taylor_q15(HALF_PI_Q30 * rr / TAB_N);
      sin_q15[k] = (q >= 2) ? -v : v;
    end
    for (int i = 0; i < 4; i++) held_w[i] = '0;
    lim_x = 15'd3000;
    lim_y = 15'd3000;
    lim_turn = 15'd300;
    arm_q16 = 24'd65536;
    rpm_q16 = 24'd65536;
    mismatches = 0;
    results_seen = 0;
    sat_seen = 0;
    relax_seen = 0;
    cycles = 0;
    send_idle_pct = 30;
    recv_stall_pct = 48;
    none = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_STOP;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.vel_turn = '0;
    in_ch.rel_angle = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    rows = '{
      '{'{MODE_FLY, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1,
        flat(16'd0, 16'd0, 16'd0, 16'd0, 1'b0)},
      '{'{MODE_RELAX, 16'sd5, 16'sd5, 16'sd5, 16'd0}, 1'b1,
        flat(16'd0, 16'd0, 16'd0, 16'd0, 1'b1)},
      '{'{MODE_OPEN, 16'sd100, 16'sd0, 16'sd0, 16'd0}, 1'b1,
        flat(16'd100, 16'd100, -16'sd100, -16'sd100, 1'b0)},
      '{'{MODE_AUTO, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1,
        flat(16'd100, 16'd100, -16'sd100, -16'sd100, 1'b0)},
      '{'{MODE_OTHER, 16'sd0, 16'sd0, 16'sd0, 16'd0}, 1'b1,
        flat(16'd100, 16'd100, -16'sd100, -16'sd100, 1'b1)},
      '{'{MODE_STOP, 16'sd7, 16'sd7, 16'sd7, 16'hFFFF}, 1'b1,
        flat(16'd0, 16'd0, 16'd0, 16'd0, 1'b0)},
      '{'{MODE_OPEN, 16'sd0, 16'sd0, 16'sh7FFF, 16'd0}, 1'b1,
        flat(16'd300, 16'd300, 16'd300, 16'd300, 1'b0)},
      '{'{MODE_OPEN, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'd0}, 1'b0, none},
      '{'{MODE_OPEN, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'd0}, 1'b0, none},
      '{'{MODE_OPEN, 16'sh8000, 16'sh7FFF, 16'sd0, 16'd0}, 1'b0, none},
      '{'{MODE_FOLLOW, 16'sd1000, 16'sd0, 16'sd0, 16'd0}, 1'b0, none},
      '{'{MODE_FOLLOW, 16'sd1000, 16'sd0, 16'sd0, 16'd16384}, 1'b0, none},
      '{'{MODE_FOLLOW, 16'sd1000, 16'sd500, 16'sd50, 16'd32768}, 1'b0, none},
      '{'{MODE_FOLLOW, 16'sh8000, 16'sh7FFF, 16'sd0, 16'd49152}, 1'b0, none},
      '{'{MODE_SPIN, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'hFFFF}, 1'b0, none},
      '{'{MODE_SPIN, 16'sd1234, 16'sd4321, 16'sd200, 16'd8192}, 1'b0, none},
      '{'{MODE_SPIN, 16'sd1, 16'sd1, 16'sd1, 16'd63}, 1'b0, none},
      '{'{MODE_SPIN, -16'sd1, -16'sd1, -16'sd1, 16'd64}, 1'b0, none},
      '{'{MODE_FOLLOW, 16'sd0, -16'sd2500, 16'sd0, 16'hAAAA}, 1'b0, none},
      '{'{MODE_FOLLOW, -16'sd2500, 16'sd0, 16'sd0, 16'h5555}, 1'b0, none}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_cmd(r.cmd, r.typed, r.want);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 150) begin
        send_idle_pct = 48;
        recv_stall_pct = 30;
      end
      if (n == 300) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      if (n % 75 == 0) begin
        case ((n / 75) % 6)
          0: load_limits(24'h7FFF, 24'h7FFF, 24'h7FFF, 24'hFFFFFF, 24'hFFFFFF);
          1: load_limits(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
          2: load_limits(24'd3000, 24'd3000, 24'd300, 24'd65536, 24'd65536);
          3: load_limits(24'h7FFF, 24'h7FFF, 24'h7FFF, 24'd65536, 24'd400000);
          4: load_limits(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                         24'($urandom));
          default: load_limits(24'h7FFF, 24'd0, 24'd1, 24'hFFFFFF, 24'd1);
        endcase
      end
      send_cmd(random_cmd(), 1'b0, none);
    end

    while (wheels_due.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("commands checked: %0d results, %0d saturated, %0d with motors relaxed",
             results_seen, sat_seen, relax_seen);
    $display("covered every mode, six register settings and three handshake pacing phases");
    if (mismatches == 0 && wheels_due.size() == 0) begin
      $display("omni_chassis_wheel_mixer_tb OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, wheels_due.size());
      $display("omni_chassis_wheel_mixer_tb NOT OK");
    end
    $finish;
  end

endmodule
